// ----- rtl/core/ufr_pkg.sv -----
// shared types and constants of the frame receiver
`default_nettype none

package ufr_pkg;

    localparam logic [7:0] SYNC_FIRST  = 8'hB5;
    localparam logic [7:0] SYNC_SECOND = 8'h62;

    localparam logic [2:0] EV_PAYLOAD  = 3'd0;
    localparam logic [2:0] EV_OK       = 3'd1;
    localparam logic [2:0] EV_BAD_SUM  = 3'd2;
    localparam logic [2:0] EV_BAD_SYNC = 3'd3;
    localparam logic [2:0] EV_TOO_LONG = 3'd4;

    localparam logic [15:0] MAX_LEN_RESET = 16'hFFFF;

    // register byte addresses
    localparam logic [1:0] REG_MAX_LEN = 2'd0;

    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  data;
        logic [15:0] index;
        logic [7:0]  msg_class;
        logic [7:0]  msg_id;
        logic [15:0] msg_length;
    } t_event;

endpackage

`default_nettype wire

// ----- rtl/core/ufr_if.sv -----
// channel interfaces of the frame receiver
`default_nettype none

interface ufr_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

interface ufr_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  event_kind;
    logic [7:0]  payload_byte;
    logic [15:0] payload_index;
    logic [7:0]  msg_class;
    logic [7:0]  msg_id;
    logic [15:0] msg_length;
    logic        frame_end;

    modport source (
        output valid, output event_kind, output payload_byte, output payload_index,
        output msg_class, output msg_id, output msg_length, output frame_end,
        input ready
    );
    modport sink (
        input valid, input event_kind, input payload_byte, input payload_index,
        input msg_class, input msg_id, input msg_length, input frame_end,
        output ready
    );
endinterface

`default_nettype wire

// ----- rtl/core/ufr_front.sv -----
// frame parser: sync hunt, header, payload indexing and checksum check
`default_nettype none

module ufr_front (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    ufr_in_if.sink              i_in,
    input  wire logic           i_full,
    input  wire logic [15:0]    i_max_len,
    output ufr_pkg::t_event     o_evt,
    output logic                o_push
);
    import ufr_pkg::*;

    localparam logic [3:0] PH_HUNT    = 4'd0;
    localparam logic [3:0] PH_SYNC2   = 4'd1;
    localparam logic [3:0] PH_CLASS   = 4'd2;
    localparam logic [3:0] PH_ID      = 4'd3;
    localparam logic [3:0] PH_LEN_LO  = 4'd4;
    localparam logic [3:0] PH_LEN_HI  = 4'd5;
    localparam logic [3:0] PH_PAYLOAD = 4'd6;
    localparam logic [3:0] PH_CK_A    = 4'd7;
    localparam logic [3:0] PH_CK_B    = 4'd8;

    logic [3:0]  r_phase, n_phase;
    logic [7:0]  r_class, n_class;
    logic [7:0]  r_id, n_id;
    logic [15:0] r_len, n_len;
    logic [15:0] r_count, n_count;
    logic [7:0]  r_sum_a, n_sum_a;
    logic [7:0]  r_sum_b, n_sum_b;
    logic [7:0]  r_rx_a, n_rx_a;

    logic        take;
    logic [7:0]  b;
    logic [7:0]  acc_a;
    logic [7:0]  acc_b;
    logic [15:0] full_len;

    assign i_in.ready = ~i_full;
    assign take       = i_in.valid & ~i_full;
    assign b          = i_in.rx_byte;

    // running fletcher sum with this byte folded in
    assign acc_a    = r_sum_a + b;
    assign acc_b    = r_sum_b + acc_a;
    assign full_len = {b, r_len[7:0]};

    always_comb begin
        n_phase = r_phase;
        n_class = r_class;
        n_id    = r_id;
        n_len   = r_len;
        n_count = r_count;
        n_sum_a = r_sum_a;
        n_sum_b = r_sum_b;
        n_rx_a  = r_rx_a;
        o_push  = 1'b0;
        o_evt   = '{kind: EV_PAYLOAD, data: 8'd0, index: 16'd0,
                    msg_class: r_class, msg_id: r_id, msg_length: r_len};
        case (r_phase)
            PH_HUNT: begin
                if (b == SYNC_FIRST) begin
                    n_phase = PH_SYNC2;
                end
            end
            PH_SYNC2: begin
                if (b == SYNC_SECOND) begin
                    n_phase = PH_CLASS;
                end else begin
                    n_phase          = PH_HUNT;
                    o_push           = 1'b1;
                    o_evt.kind       = EV_BAD_SYNC;
                    o_evt.msg_class  = 8'd0;
                    o_evt.msg_id     = 8'd0;
                    o_evt.msg_length = 16'd0;
                end
            end
            PH_CLASS: begin
                n_class = b;
                n_id    = 8'd0;
                n_len   = 16'd0;
                n_count = 16'd0;
                n_sum_a = b;
                n_sum_b = b;
                n_phase = PH_ID;
            end
            PH_ID: begin
                n_id    = b;
                n_sum_a = acc_a;
                n_sum_b = acc_b;
                n_phase = PH_LEN_LO;
            end
            PH_LEN_LO: begin
                n_len   = {8'd0, b};
                n_sum_a = acc_a;
                n_sum_b = acc_b;
                n_phase = PH_LEN_HI;
            end
            PH_LEN_HI: begin
                n_len   = full_len;
                n_sum_a = acc_a;
                n_sum_b = acc_b;
                n_count = 16'd0;
                if (full_len > i_max_len) begin
                    n_phase          = PH_HUNT;
                    o_push           = 1'b1;
                    o_evt.kind       = EV_TOO_LONG;
                    o_evt.msg_length = full_len;
                end else if (full_len == 16'd0) begin
                    n_phase = PH_CK_A;
                end else begin
                    n_phase = PH_PAYLOAD;
                end
            end
            PH_PAYLOAD: begin
                o_push      = 1'b1;
                o_evt.kind  = EV_PAYLOAD;
                o_evt.data  = b;
                o_evt.index = r_count;
                n_sum_a     = acc_a;
                n_sum_b     = acc_b;
                n_count     = r_count + 16'd1;
                if (n_count == r_len) begin
                    n_phase = PH_CK_A;
                end
            end
            PH_CK_A: begin
                n_rx_a  = b;
                n_phase = PH_CK_B;
            end
            PH_CK_B: begin
                n_phase    = PH_HUNT;
                o_push     = 1'b1;
                o_evt.kind = ((r_rx_a == r_sum_a) && (b == r_sum_b)) ? EV_OK : EV_BAD_SUM;
            end
            default: begin
                n_phase = PH_HUNT;
            end
        endcase
        if (!take) begin
            o_push = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HUNT;
            r_class <= 8'd0;
            r_id    <= 8'd0;
            r_len   <= 16'd0;
            r_count <= 16'd0;
            r_sum_a <= 8'd0;
            r_sum_b <= 8'd0;
            r_rx_a  <= 8'd0;
        end else if (take) begin
            r_phase <= n_phase;
            r_class <= n_class;
            r_id    <= n_id;
            r_len   <= n_len;
            r_count <= n_count;
            r_sum_a <= n_sum_a;
            r_sum_b <= n_sum_b;
            r_rx_a  <= n_rx_a;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/ufr_queue.sv -----
// short event queue between parser and output stage
`default_nettype none

module ufr_queue #(
    parameter int DEPTH = 4
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire ufr_pkg::t_event i_evt,
    output logic                o_full,
    output logic                o_valid,
    input  wire logic           i_pop,
    output ufr_pkg::t_event     o_evt
);
    import ufr_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL = CW'(DEPTH);

    t_event        r_mem [DEPTH];
    logic [PW-1:0] r_wr, r_rd;
    logic [CW-1:0] r_cnt;
    logic          do_pop;

    assign o_full  = (r_cnt == FULL);
    assign o_valid = (r_cnt != '0);
    assign o_evt   = r_mem[r_rd];
    assign do_pop  = i_pop & o_valid;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_evt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == LAST) ? '0 : r_wr + PW'(1);
            end
            if (do_pop) begin
                r_rd <= (r_rd == LAST) ? '0 : r_rd + PW'(1);
            end
            case ({i_push, do_pop})
                2'b10:   r_cnt <= r_cnt + CW'(1);
                2'b01:   r_cnt <= r_cnt - CW'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/ufr_back.sv -----
// output stage: result register and field formatting
`default_nettype none

module ufr_back (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_valid,
    input  wire ufr_pkg::t_event i_evt,
    output logic                o_pop,
    ufr_out_if.source           o_out
);
    import ufr_pkg::*;

    logic   r_valid;
    t_event r_evt;
    logic   load;

    assign load  = ~r_valid | o_out.ready;
    assign o_pop = i_valid & load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_evt <= i_evt;
        end
    end

    assign o_out.valid         = r_valid;
    assign o_out.event_kind    = r_evt.kind;
    assign o_out.payload_byte  = r_evt.data;
    assign o_out.payload_index = r_evt.index;
    assign o_out.msg_class     = r_evt.msg_class;
    assign o_out.msg_id        = r_evt.msg_id;
    assign o_out.msg_length    = r_evt.msg_length;
    assign o_out.frame_end     = (r_evt.kind != EV_PAYLOAD);

endmodule

`default_nettype wire

// ----- rtl/core/ubx_frame_receiver_core.sv -----
// top level of the ubx frame receiver: parser, event queue, output stage, register port
// throughput: one byte beat per cycle while the event queue has room
// each result beat passes the queue, then the output register, before it is taken
// bytes that raise no result (sync, header, checksum a) only advance the parser
// reset: synchronous active-low i_rst_n puts the parser in sync hunt, empties
// the queue and the output register, and sets max_payload_length to 65535
`default_nettype none

module ubx_frame_receiver_core #(
    parameter int QUEUE_DEPTH = 4
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    ufr_in_if.sink           i_in,
    ufr_out_if.source        o_out,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [1:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    import ufr_pkg::*;

    // length limit register, checked when the second length byte arrives
    logic [15:0] r_max_len;
    logic        cfg_wr;

    // parser to queue
    t_event      front_evt;
    logic        front_push;
    logic        q_full;

    // queue to output stage
    t_event      q_evt;
    logic        q_valid;
    logic        back_pop;

    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_len <= MAX_LEN_RESET;
        end else if (cfg_wr && (paddr == REG_MAX_LEN)) begin
            r_max_len <= pwdata[15:0];
        end
    end

    // unknown addresses read as zero
    assign prdata = (paddr == REG_MAX_LEN) ? {16'd0, r_max_len} : 32'd0;

    // front: takes bytes whenever the queue has room
    ufr_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (i_in),
        .i_full    (q_full),
        .i_max_len (r_max_len),
        .o_evt     (front_evt),
        .o_push    (front_push)
    );

    // queue decouples a stalled output from the parser
    ufr_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_push),
        .i_evt   (front_evt),
        .o_full  (q_full),
        .o_valid (q_valid),
        .i_pop   (back_pop),
        .o_evt   (q_evt)
    );

    // back: registered result beat
    ufr_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_valid),
        .i_evt   (q_evt),
        .o_pop   (back_pop),
        .o_out   (o_out)
    );

endmodule

`default_nettype wire

// ----- tb/tb_ubx_frame_receiver_core.sv -----
// self-checking testbench of the ubx frame receiver: directed table, random frames, predictor
`timescale 1ns / 1ps

module tb_ubx_frame_receiver_core;

    import ufr_pkg::*;

    // run shape
    localparam int CLK_HALF       = 4;
    localparam int PHASE_BYTES    = 110;   // random byte beats per register setting
    localparam int RANDOM_PHASES  = 6;
    localparam int SETTLE_CYCLES  = 4;     // results pass the queue and output reg
    localparam int HOLD_CYCLES    = 150;   // long receiver hold-off, fills the event queue
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int DIR_ROWS       = 29;

    // one expected result beat: packaged event fields plus the frame end flag
    typedef struct packed {
        t_event ev;
        logic   frame_end;
    } t_rx_event;

    // predictor parse phases
    typedef enum logic [3:0] {
        P_HUNT, P_SYNC2, P_CLASS, P_ID, P_LEN_LO, P_LEN_HI, P_PAYLOAD, P_CK_A, P_CK_B
    } t_parse_phase;

    // directed table: a byte beat, or a write of the length limit
    typedef enum logic {ROW_BYTE, ROW_MAX_LEN} t_row_op;

    typedef struct {
        t_row_op   op;
        logic [15:0] value;
        logic      pinned;     // typed-in result replaces the predicted one
        t_rx_event pin_ev;
    } t_stim_row;

    localparam t_rx_event NO_EVENT = '0;
    localparam t_rx_event BAD_SYNC_EVENT =
        '{'{EV_BAD_SYNC, 8'h00, 16'h0000, 8'h00, 8'h00, 16'h0000}, 1'b1};
    localparam t_rx_event OK_EMPTY_EVENT =
        '{'{EV_OK, 8'h00, 16'h0000, 8'hFF, 8'h00, 16'h0000}, 1'b1};
    localparam t_rx_event TOO_LONG_EVENT =
        '{'{EV_TOO_LONG, 8'h00, 16'h0000, 8'h01, 8'h02, 16'hFFFF}, 1'b1};

    t_stim_row directed_rows [DIR_ROWS] = '{
        // noise before any sync, all bits low then high
        '{ROW_BYTE, 16'h0000, 1'b0, NO_EVENT},
        '{ROW_BYTE, 16'h00FF, 1'b0, NO_EVENT},
        // repeated first sync: the second one is eaten as a bad second sync
        '{ROW_BYTE, 16'h00B5, 1'b0, NO_EVENT},
        '{ROW_BYTE, 16'h00B5, 1'b1, BAD_SYNC_EVENT},
        // so this 0x62 is only noise
        '{ROW_BYTE, 16'h0062, 1'b0, NO_EVENT},
        // empty payload, class 0xff id 0x00, good checksum
        '{ROW_BYTE, 16'h00B5, 1'b0, NO_EVENT},
        '{ROW_BYTE, 16'h0062, 1'b0, NO_EVENT},
        '{ROW_BYTE, 16'h00FF, 1'b0, NO_EVENT},
        '{ROW_BYTE, 16'h0000, 1'b0, NO_EVENT},
        '{ROW_BYTE, 16'h0000, 1'b0, NO_EVENT},
        '{ROW_BYTE, 16'h0000, 1'b0, NO_EVENT},
        '{ROW_BYTE, 16'h00FF, 1'b0, NO_EVENT},
        '{ROW_BYTE, 16'h00FC, 1'b1, OK_EMPTY_EVENT},
        // one payload byte, wrong checksum
        '{ROW_BYTE, 16'h00B5, 1'b0, NO_EVENT},
        '{ROW_BYTE, 16'h0062, 1'b0, NO_EVENT},
        '{ROW_BYTE, 16'h0000, 1'b0, NO_EVENT},
        '{ROW_BYTE, 16'h00FF, 1'b0, NO_EVENT},
        '{ROW_BYTE, 16'h0001, 1'b0, NO_EVENT},
        '{ROW_BYTE, 16'h0000, 1'b0, NO_EVENT},
        '{ROW_BYTE, 16'h00FF, 1'b0, NO_EVENT},
        '{ROW_BYTE, 16'h0000, 1'b0, NO_EVENT},
        '{ROW_BYTE, 16'h0000, 1'b0, NO_EVENT},
        // limit drops to zero between the length bytes, then length 0xffff
        '{ROW_BYTE, 16'h00B5, 1'b0, NO_EVENT},
        '{ROW_BYTE, 16'h0062, 1'b0, NO_EVENT},
        '{ROW_BYTE, 16'h0001, 1'b0, NO_EVENT},
        '{ROW_BYTE, 16'h0002, 1'b0, NO_EVENT},
        '{ROW_BYTE, 16'h00FF, 1'b0, NO_EVENT},
        '{ROW_MAX_LEN, 16'h0000, 1'b0, NO_EVENT},
        '{ROW_BYTE, 16'h00FF, 1'b1, TOO_LONG_EVENT}
    };

    logic        i_clk;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [1:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    ufr_in_if  rx_bus ();
    ufr_out_if ev_bus ();

    ubx_frame_receiver_core uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (rx_bus),
        .o_out   (ev_bus),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // predictor copy of the parser state and the length limit
    t_parse_phase parse_at      = P_HUNT;
    logic [7:0]   hdr_class     = 8'h00;
    logic [7:0]   hdr_id        = 8'h00;
    logic [15:0]  hdr_length    = 16'h0000;
    logic [15:0]  payload_count = 16'h0000;
    logic [7:0]   run_a         = 8'h00;
    logic [7:0]   run_b         = 8'h00;
    logic [7:0]   got_ck_a      = 8'h00;
    logic [15:0]  max_len_cfg   = MAX_LEN_RESET;

    // result beats still owed by the block, oldest first
    t_rx_event events_due [$];

    int unsigned bytes_sent       = 0;
    int unsigned mismatches       = 0;
    int unsigned settings_written = 0;
    int unsigned kind_count [5]   = '{0, 0, 0, 0, 0};
    int unsigned quiet_cycles     = 0;

    // idling knobs, percent chance per beat of starting an idle burst
    int unsigned gap_pct       = 0;
    int unsigned stall_pct     = 0;
    int unsigned hold_requests = 0;
    int unsigned holds_done    = 0;
    int unsigned hold_left     = 0;
    int unsigned stall_left    = 0;

    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // 8-bit fletcher running sum, shared by the predictor and the frame builder
    function automatic void fold_sum(inout logic [7:0] a, inout logic [7:0] b,
                                     input logic [7:0] x);
        a = a + x;
        b = b + a;
    endfunction

    function automatic t_rx_event header_event(input logic [2:0] kind, input logic [7:0] data,
                                               input logic [15:0] idx, input logic last);
        t_rx_event e;
        e.ev.kind       = kind;
        e.ev.data       = data;
        e.ev.index      = idx;
        e.ev.msg_class  = hdr_class;
        e.ev.msg_id     = hdr_id;
        e.ev.msg_length = hdr_length;
        e.frame_end     = last;
        return e;
    endfunction

    // advance the predicted parser by one byte; returns 1 when a result beat is owed
    function automatic logic parse_rx_byte(input logic [7:0] b, output t_rx_event e);
        e = '0;
        case (parse_at)
            P_HUNT: begin
                if (b == SYNC_FIRST) parse_at = P_SYNC2;
                return 1'b0;
            end
            P_SYNC2: begin
                if (b == SYNC_SECOND) begin
                    parse_at = P_CLASS;
                    return 1'b0;
                end
                // header fields are reported as zero here
                parse_at    = P_HUNT;
                e.ev.kind   = EV_BAD_SYNC;
                e.frame_end = 1'b1;
                return 1'b1;
            end
            P_CLASS: begin
                hdr_class     = b;
                hdr_id        = 8'h00;
                hdr_length    = 16'h0000;
                payload_count = 16'h0000;
                run_a         = 8'h00;
                run_b         = 8'h00;
                fold_sum(run_a, run_b, b);
                parse_at = P_ID;
                return 1'b0;
            end
            P_ID: begin
                hdr_id = b;
                fold_sum(run_a, run_b, b);
                parse_at = P_LEN_LO;
                return 1'b0;
            end
            P_LEN_LO: begin
                hdr_length = {8'h00, b};
                fold_sum(run_a, run_b, b);
                parse_at = P_LEN_HI;
                return 1'b0;
            end
            P_LEN_HI: begin
                hdr_length[15:8] = b;
                fold_sum(run_a, run_b, b);
                payload_count = 16'h0000;
                // limit in force at the second length byte decides
                if (hdr_length > max_len_cfg) begin
                    parse_at = P_HUNT;
                    e = header_event(EV_TOO_LONG, 8'h00, 16'h0000, 1'b1);
                    return 1'b1;
                end
                parse_at = (hdr_length == 16'h0000) ? P_CK_A : P_PAYLOAD;
                return 1'b0;
            end
            P_PAYLOAD: begin
                e = header_event(EV_PAYLOAD, b, payload_count, 1'b0);
                fold_sum(run_a, run_b, b);
                payload_count = payload_count + 16'd1;
                if (payload_count == hdr_length) parse_at = P_CK_A;
                return 1'b1;
            end
            P_CK_A: begin
                got_ck_a = b;
                parse_at = P_CK_B;
                return 1'b0;
            end
            P_CK_B: begin
                parse_at = P_HUNT;
                e = header_event((got_ck_a == run_a && b == run_b) ? EV_OK : EV_BAD_SUM,
                                 8'h00, 16'h0000, 1'b1);
                return 1'b1;
            end
            default: begin
                parse_at = P_HUNT;
                return 1'b0;
            end
        endcase
    endfunction

    // offer one byte beat, wait for it to be taken, then book its expected result
    task automatic send_byte(input logic [7:0] value, input logic pinned = 1'b0,
                             input t_rx_event pin_ev = '0);
        t_rx_event e;
        logic      owed;
        if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
            rx_bus.valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge i_clk);
        end
        rx_bus.valid   <= 1'b1;
        rx_bus.rx_byte <= value;
        do @(posedge i_clk); while (rx_bus.ready !== 1'b1);
        bytes_sent++;
        owed = parse_rx_byte(value, e);
        if (pinned) events_due.push_back(pin_ev);
        else if (owed) events_due.push_back(e);
    endtask

    // stop offering bytes and wait until every owed result beat is in
    task automatic drain_results();
        rx_bus.valid <= 1'b0;
        while (events_due.size() != 0) @(posedge i_clk);
        // header and checksum-a bytes owe nothing but may still be in flight
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // apb write of the length limit on an idle block, then read it back
    task automatic write_max_len(input logic [15:0] limit);
        drain_results();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= REG_MAX_LEN;
        pwdata  <= {16'h0000, limit};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        max_len_cfg = limit;
        settings_written++;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        if (prdata[15:0] !== limit) begin
            mismatches++;
            $display("%0t: max_payload_length readback expected 0x%0h got 0x%0h",
                     $time, limit, prdata[15:0]);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // one random frame, mostly well formed; force_len >= 0 fixes the payload length
    task automatic send_random_frame(input logic [15:0] limit, input int force_len);
        int unsigned roll;
        int          i;
        logic [15:0] len;
        logic [7:0]  cls;
        logic [7:0]  id;
        logic [7:0]  ck_a;
        logic [7:0]  ck_b;
        logic [7:0]  x;
        roll = $urandom_range(0, 99);
        // leading noise, kept clear of the first sync so frames stay aligned
        if (force_len < 0 && roll < 8) begin
            repeat ($urandom_range(1, 4)) begin
                x = 8'($urandom);
                if (x == SYNC_FIRST) x = 8'h00;
                send_byte(x);
            end
        end
        // broken sync pair
        if (force_len < 0 && roll >= 8 && roll < 16) begin
            send_byte(SYNC_FIRST);
            x = 8'($urandom);
            if (x == SYNC_SECOND) x = SYNC_FIRST;
            send_byte(x);
            return;
        end
        cls = 8'($urandom);
        id  = 8'($urandom);
        if (force_len >= 0)
            len = 16'(force_len);
        else if (roll >= 16 && roll < 26 && limit != 16'hFFFF)
            len = (roll < 18) ? 16'hFFFF : 16'($urandom_range(limit + 1, 16'hFFFF));
        else if (roll < 36)
            len = 16'($urandom_range(13, 48));
        else
            len = 16'($urandom_range(0, 12));
        ck_a = 8'h00;
        ck_b = 8'h00;
        fold_sum(ck_a, ck_b, cls);
        fold_sum(ck_a, ck_b, id);
        fold_sum(ck_a, ck_b, len[7:0]);
        fold_sum(ck_a, ck_b, len[15:8]);
        send_byte(SYNC_FIRST);
        send_byte(SYNC_SECOND);
        send_byte(cls);
        send_byte(id);
        send_byte(len[7:0]);
        send_byte(len[15:8]);
        // rejected header, the block is back hunting
        if (len > limit) return;
        for (i = 0; i < len; i++) begin
            x = 8'($urandom);
            fold_sum(ck_a, ck_b, x);
            send_byte(x);
        end
        if ($urandom_range(0, 3) == 0) begin
            case ($urandom_range(0, 2))
                0: ck_a = ck_a ^ 8'($urandom_range(1, 255));
                1: ck_b = ck_b ^ 8'($urandom_range(1, 255));
                default: begin
                    ck_a = ck_a ^ 8'($urandom_range(1, 255));
                    ck_b = ck_b ^ 8'($urandom_range(1, 255));
                end
            endcase
        end
        send_byte(ck_a);
        send_byte(ck_b);
    endtask

    task automatic check_field(input string field, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want) begin
            mismatches++;
            $display("%0t: %s expected 0x%0h got 0x%0h", $time, field, want, got);
        end
    endtask

    // receiver side: random stall bursts, plus a long hold-off on request
    initial begin
        ev_bus.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (holds_done != hold_requests) begin
                holds_done = hold_requests;
                hold_left  = HOLD_CYCLES;
            end
            if (hold_left != 0) begin
                hold_left--;
                ev_bus.ready <= 1'b0;
            end else if (stall_left != 0) begin
                stall_left--;
                ev_bus.ready <= 1'b0;
            end else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
                stall_left = $urandom_range(0, 14);
                ev_bus.ready <= 1'b0;
            end else begin
                ev_bus.ready <= 1'b1;
            end
        end
    end

    // result beats against the oldest owed result, field by field
    always @(posedge i_clk) begin : check_results
        t_rx_event got;
        t_rx_event want;
        if (i_rst_n === 1'b1 && ev_bus.valid === 1'b1 && ev_bus.ready === 1'b1) begin
            got.ev.kind       = ev_bus.event_kind;
            got.ev.data       = ev_bus.payload_byte;
            got.ev.index      = ev_bus.payload_index;
            got.ev.msg_class  = ev_bus.msg_class;
            got.ev.msg_id     = ev_bus.msg_id;
            got.ev.msg_length = ev_bus.msg_length;
            got.frame_end     = ev_bus.frame_end;
            if (events_due.size() == 0) begin
                mismatches++;
                $display("%0t: result beat with nothing owed, kind 0x%0h", $time, got.ev.kind);
            end else begin
                want = events_due.pop_front();
                check_field("event_kind", 16'(want.ev.kind), 16'(got.ev.kind));
                check_field("payload_byte", 16'(want.ev.data), 16'(got.ev.data));
                check_field("payload_index", want.ev.index, got.ev.index);
                check_field("msg_class", 16'(want.ev.msg_class), 16'(got.ev.msg_class));
                check_field("msg_id", 16'(want.ev.msg_id), 16'(got.ev.msg_id));
                check_field("msg_length", want.ev.msg_length, got.ev.msg_length);
                check_field("frame_end", 16'(want.frame_end), 16'(got.frame_end));
                if (want.ev.kind <= EV_TOO_LONG) kind_count[want.ev.kind]++;
            end
        end
    end

    // watchdog: any beat on either channel or the register port counts as progress
    always @(posedge i_clk) begin
        if ((rx_bus.valid === 1'b1 && rx_bus.ready === 1'b1) ||
            (ev_bus.valid === 1'b1 && ev_bus.ready === 1'b1) ||
            (psel === 1'b1 && penable === 1'b1))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no beat for %0d cycles, %0d results still owed",
                     quiet_cycles, events_due.size());
            $display("FAIL");
            $finish;
        end
    end

    // stimulus
    initial begin
        int          p;
        int          r;
        logic [15:0] limit;
        int unsigned phase_start;
        bit          paused;

        i_rst_n        = 1'b0;
        rx_bus.valid   = 1'b0;
        rx_bus.rx_byte = 8'h00;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = REG_MAX_LEN;
        pwdata         = 32'h0;
        paused         = 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed table at the reset limit of 65535
        for (r = 0; r < DIR_ROWS; r++) begin
            if (directed_rows[r].op == ROW_MAX_LEN)
                write_max_len(directed_rows[r].value);
            else
                send_byte(directed_rows[r].value[7:0], directed_rows[r].pinned,
                          directed_rows[r].pin_ev);
        end

        // random frames under a series of limits, extremes included
        for (p = 0; p < RANDOM_PHASES; p++) begin
            case (p)
                0: limit = 16'hFFFF;
                1: limit = 16'h0000;
                2: limit = 16'h0001;
                3: limit = 16'($urandom_range(2, 20));
                4: limit = 16'($urandom_range(16'h0100, 16'hFFFE));
                default: limit = 16'hFFFF;
            endcase
            write_max_len(limit);
            phase_start = bytes_sent;
            if (p == RANDOM_PHASES - 1) begin
                // closing stretch runs with no idling at all
                gap_pct   = 0;
                stall_pct = 0;
            end
            if (p == 0) begin
                // receiver holds off while a long payload keeps coming
                hold_requests++;
                send_random_frame(limit, 40);
            end
            while (bytes_sent - phase_start < PHASE_BYTES) begin
                if (p != RANDOM_PHASES - 1 && $urandom_range(0, 7) == 0) begin
                    case ($urandom_range(0, 2))
                        0: gap_pct = 0;
                        1: gap_pct = 10;
                        default: gap_pct = 30;
                    endcase
                    case ($urandom_range(0, 2))
                        0: stall_pct = 0;
                        1: stall_pct = 10;
                        default: stall_pct = 30;
                    endcase
                end
                send_random_frame(limit, -1);
                // sender pauses once mid-phase until the block has emptied out
                if (p == 2 && !paused && bytes_sent - phase_start > 50) begin
                    drain_results();
                    paused = 1'b1;
                end
            end
        end

        drain_results();
        mismatches += events_due.size();

        $display("covered %0d byte beats over %0d limit settings, including a full hold-off",
                 bytes_sent, settings_written);
        $display("results seen: %0d payload, %0d ok, %0d bad sum, %0d bad sync, %0d too long",
                 kind_count[EV_PAYLOAD], kind_count[EV_OK], kind_count[EV_BAD_SUM],
                 kind_count[EV_BAD_SYNC], kind_count[EV_TOO_LONG]);
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
